### rtl/klot_pkg.sv
// ============================================================================
// klot_pkg
// shared types and constants of the keyed ordered list table
// ============================================================================
`default_nettype none

package klot_pkg;

  // fixed field widths of the request and result channels
  localparam int FUNC_W    = 3;
  localparam int KEY_W     = 32;
  localparam int PAY_IN_W  = 32;
  localparam int CNT_OUT_W = 5;

  // parameter defaults
  localparam int DEPTH_DEF        = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  // request function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INS_HEAD = 3'd0,
    FN_INS_TAIL = 3'd1,
    FN_REMOVE   = 3'd2,
    FN_UPDATE   = 3'd3,
    FN_SEARCH   = 3'd4
  } func_t;

  // per-cell action in the execute cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT,
    CELL_LOAD,
    CELL_SET_PAY
  } cell_op_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic  exec;
    func_t func;
    logic  full;
  } cell_ctl_t;

  // sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

`default_nettype wire

### rtl/klot_req_if.sv
// ============================================================================
// klot_req_if
// request channel: function code, key and payload with valid/ready
// ============================================================================
`default_nettype none

interface klot_req_if import klot_pkg::*; ;

  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [KEY_W-1:0]    req_key;
  logic [PAY_IN_W-1:0]        req_payload;

  modport source (output valid, func, req_key, req_payload, input ready);
  modport sink   (input valid, func, req_key, req_payload, output ready);
endinterface

`default_nettype wire

### rtl/klot_rsp_if.sv
// ============================================================================
// klot_rsp_if
// result channel: status, found entry and entry count with valid/ready
// ============================================================================
`default_nettype none

interface klot_rsp_if import klot_pkg::*; ;

  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic signed [KEY_W-1:0]    found_key;
  logic [PAY_IN_W-1:0]        found_payload;
  logic [CNT_OUT_W-1:0]       entry_count;

  modport source (output valid, ok, found_key, found_payload, entry_count, input ready);
  modport sink   (input valid, ok, found_key, found_payload, entry_count, output ready);
endinterface

`default_nettype wire

### rtl/klot_cell.sv
// ============================================================================
// klot_cell
// one slot of the table: key/payload storage, key compare, first-hit chain
// and neighbor shifting
// ============================================================================
`default_nettype none

module klot_cell import klot_pkg::*; #(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    capture,
  input  logic                    occupied,
  input  logic [KEY_W-1:0]        cmp_key,
  input  cell_ctl_t               ctl,
  input  logic                    at_tail,
  input  logic                    hit_in,
  output logic                    hit_out,
  output logic                    first,
  input  logic [KEY_W-1:0]        load_key,
  input  logic [PAYLOAD_BITS-1:0] load_pay,
  input  logic [KEY_W-1:0]        prev_key,
  input  logic [PAYLOAD_BITS-1:0] prev_pay,
  input  logic [KEY_W-1:0]        next_key,
  input  logic [PAYLOAD_BITS-1:0] next_pay,
  output logic [KEY_W-1:0]        key,
  output logic [PAYLOAD_BITS-1:0] pay
);

  logic     match;
  cell_op_t op;

  // first hit from the head: no earlier cell matched
  assign first   = match & ~hit_in;
  assign hit_out = hit_in | match;

  always_comb begin
    op = CELL_HOLD;
    if (ctl.exec) begin
      case (ctl.func)
        FN_INS_HEAD: if (!ctl.full) op = CELL_FROM_PREV;
        FN_INS_TAIL: if (!ctl.full && at_tail) op = CELL_LOAD;
        FN_REMOVE:   if (hit_out) op = CELL_FROM_NEXT;
        FN_UPDATE:   if (first) op = CELL_SET_PAY;
        default:     op = CELL_HOLD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      match <= occupied && (key == cmp_key);
    end
    case (op)
      CELL_FROM_PREV: begin
        key <= prev_key;
        pay <= prev_pay;
      end
      CELL_FROM_NEXT: begin
        key <= next_key;
        pay <= next_pay;
      end
      CELL_LOAD: begin
        key <= load_key;
        pay <= load_pay;
      end
      CELL_SET_PAY: pay <= load_pay;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/keyed_ordered_list_table_core.sv
// ============================================================================
// keyed_ordered_list_table_core
// ordered table of keyed entries held in a row of cells, head at cell 0
// ============================================================================
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+--------------------------------------------
//  req     | in  | valid/ready | func, req_key, req_payload
//  rsp     | out | valid/ready | ok, found_key, found_payload, entry_count
//
//  a request has an accept and an execute cycle: the accept cycle registers
//  the key compare in every cell, the execute cycle resolves the first hit
//  along the cell chain, shifts or loads cells and fills the result register.
//  the execute cycle waits while the result register holds an untaken result;
//  a new request is taken as soon as the execute cycle is done.
//  reset clears the sequencer, the entry count and the result valid; cell
//  storage is not cleared, since only cells below the count are ever read.
//
`default_nettype none

module keyed_ordered_list_table_core import klot_pkg::*; #(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  klot_req_if.sink  req,
  klot_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  // sequencer
  state_t state, state_next;
  logic   fire;        // execute cycle that commits the request
  logic   capture;     // request accepted this cycle

  // latched request
  func_t                   func_q;
  logic [KEY_W-1:0]        key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [PAYLOAD_BITS-1:0] pay_in;

  // entry count
  logic [CW-1:0] cnt, cnt_next;
  logic          full;

  // cell row
  logic [KEY_W-1:0]        cell_key [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];
  logic [DEPTH-1:0]        occupied;
  logic [DEPTH-1:0]        at_tail;
  logic [DEPTH-1:0]        first;
  logic [DEPTH:0]          hit;
  cell_ctl_t               ctl;

  // result
  logic                    ok_next;
  logic [KEY_W-1:0]        sel_key, res_key;
  logic [PAYLOAD_BITS-1:0] sel_pay, res_pay;
  logic [PAY_IN_W-1:0]     res_pay_w;
  logic [CNT_OUT_W-1:0]    cnt_out;

  assign capture = req.valid & req.ready;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    fire       = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        // commit only once the result register has room
        if (!rsp.valid || rsp.ready) begin
          fire       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // request latch; payload kept in its low PAYLOAD_BITS bits
  // ---------------------------------------------------------------------------
  for (genvar b = 0; b < PAYLOAD_BITS; b++) begin : g_pay_in
    if (b < PAY_IN_W) begin : g_bit
      assign pay_in[b] = req.req_payload[b];
    end else begin : g_zero
      assign pay_in[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      func_q <= func_t'(req.func);
      key_q  <= req.req_key;
      pay_q  <= pay_in;
    end
  end

  // ---------------------------------------------------------------------------
  // cell row: cell 0 is the head, a head insert pulls from the request,
  // a remove closes the gap by pulling from the next cell
  // ---------------------------------------------------------------------------
  assign full   = (cnt == CW'(DEPTH));
  assign hit[0] = 1'b0;

  always_comb begin
    ctl.exec = fire;
    ctl.func = func_q;
    ctl.full = full;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0]        prev_key, next_key;
    logic [PAYLOAD_BITS-1:0] prev_pay, next_pay;

    assign occupied[i] = (CW'(i) < cnt);
    assign at_tail[i]  = (cnt == CW'(i));

    if (i == 0) begin : g_head
      assign prev_key = key_q;
      assign prev_pay = pay_q;
    end else begin : g_mid
      assign prev_key = cell_key[i-1];
      assign prev_pay = cell_pay[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      // nothing behind the last cell; what it takes lies beyond the count
      assign next_key = cell_key[i];
      assign next_pay = cell_pay[i];
    end else begin : g_inner
      assign next_key = cell_key[i+1];
      assign next_pay = cell_pay[i+1];
    end

    klot_cell #(
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk      (clk),
      .capture  (capture),
      .occupied (occupied[i]),
      .cmp_key  (req.req_key),
      .ctl      (ctl),
      .at_tail  (at_tail[i]),
      .hit_in   (hit[i]),
      .hit_out  (hit[i+1]),
      .first    (first[i]),
      .load_key (key_q),
      .load_pay (pay_q),
      .prev_key (prev_key),
      .prev_pay (prev_pay),
      .next_key (next_key),
      .next_pay (next_pay),
      .key      (cell_key[i]),
      .pay      (cell_pay[i])
    );
  end

  // first-hit entry: at most one cell has first set, so an and-or select
  always_comb begin
    sel_key = '0;
    sel_pay = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_key = sel_key | (cell_key[i] & {KEY_W{first[i]}});
      sel_pay = sel_pay | (cell_pay[i] & {PAYLOAD_BITS{first[i]}});
    end
  end

  // ---------------------------------------------------------------------------
  // result and count
  // ---------------------------------------------------------------------------
  always_comb begin
    ok_next  = 1'b0;
    cnt_next = cnt;
    res_key  = '0;
    res_pay  = '0;
    case (func_q)
      FN_INS_HEAD, FN_INS_TAIL: begin
        if (!full) begin
          ok_next  = 1'b1;
          cnt_next = cnt + CW'(1);
        end
      end
      FN_REMOVE: begin
        if (hit[DEPTH]) begin
          ok_next  = 1'b1;
          cnt_next = cnt - CW'(1);
          res_key  = sel_key;
          res_pay  = sel_pay;
        end
      end
      FN_UPDATE: begin
        // result shows the new payload
        if (hit[DEPTH]) begin
          ok_next = 1'b1;
          res_key = sel_key;
          res_pay = pay_q;
        end
      end
      FN_SEARCH: begin
        if (hit[DEPTH]) begin
          ok_next = 1'b1;
          res_key = sel_key;
          res_pay = sel_pay;
        end
      end
      default: ok_next = 1'b0;
    endcase
  end

  for (genvar b = 0; b < PAY_IN_W; b++) begin : g_res_pay
    if (b < PAYLOAD_BITS) begin : g_bit
      assign res_pay_w[b] = res_pay[b];
    end else begin : g_zero
      assign res_pay_w[b] = 1'b0;
    end
  end

  // low bits of the count
  for (genvar b = 0; b < CNT_OUT_W; b++) begin : g_cnt_out
    if (b < CW) begin : g_bit
      assign cnt_out[b] = cnt_next[b];
    end else begin : g_zero
      assign cnt_out[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (fire) cnt <= cnt_next;
      if (fire) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.ok            <= ok_next;
      rsp.found_key     <= res_key;
      rsp.found_payload <= res_pay_w;
      rsp.entry_count   <= cnt_out;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    capture |=> state == S_EXEC)
    else $error("accepted request did not reach execute");

  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp.valid)
    else $error("committed request produced no result");

  a_cnt_only_on_fire: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(cnt))
    else $error("entry count changed outside execute");

endmodule

`default_nettype wire

### tb/keyed_ordered_list_table_checker.sv
// ============================================================================
// keyed_ordered_list_table_checker
// watches both channels, keeps a shadow of the table and checks every result
// ============================================================================
`default_nettype none

module keyed_ordered_list_table_checker import klot_pkg::*; #(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  klot_req_if  req,
  klot_rsp_if  rsp,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                 ok;
    logic [KEY_W-1:0]     key;
    logic [PAY_IN_W-1:0]  payload;
    logic [CNT_OUT_W-1:0] count;
  } lookup_result_t;

  // shadow table, head at index 0
  logic [KEY_W-1:0]        shadow_key [DEPTH];
  logic [PAYLOAD_BITS-1:0] shadow_pay [DEPTH];
  int                      shadow_count;

  lookup_result_t outstanding[$];
  int             mismatches;

  function automatic lookup_result_t table_apply(input logic [FUNC_W-1:0] fn,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [PAY_IN_W-1:0] pay_in);
    lookup_result_t          res;
    logic [PAYLOAD_BITS-1:0] pay;
    int                      hit;
    res = '0;
    pay = PAYLOAD_BITS'(pay_in);
    hit = -1;
    // first match counting from the head
    for (int i = shadow_count - 1; i >= 0; i--) begin
      if (shadow_key[i] == key) hit = i;
    end
    case (fn)
      FN_INS_HEAD, FN_INS_TAIL: begin
        if (shadow_count < DEPTH) begin
          if (fn == FN_INS_HEAD) begin
            for (int i = shadow_count; i > 0; i--) begin
              shadow_key[i] = shadow_key[i-1];
              shadow_pay[i] = shadow_pay[i-1];
            end
            shadow_key[0] = key;
            shadow_pay[0] = pay;
          end else begin
            shadow_key[shadow_count] = key;
            shadow_pay[shadow_count] = pay;
          end
          shadow_count++;
          res.ok = 1'b1;
        end
      end
      FN_REMOVE, FN_UPDATE, FN_SEARCH: begin
        if (hit >= 0) begin
          res.ok = 1'b1;
          if (fn == FN_UPDATE) shadow_pay[hit] = pay;
          res.key     = shadow_key[hit];
          res.payload = PAY_IN_W'(shadow_pay[hit]);
          if (fn == FN_REMOVE) begin
            for (int i = hit; i + 1 < shadow_count; i++) begin
              shadow_key[i] = shadow_key[i+1];
              shadow_pay[i] = shadow_pay[i+1];
            end
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    res.count = CNT_OUT_W'(shadow_count);
    return res;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $error("%s: expected 0x%h, got 0x%h", field, want_v, got_v);
    end
  endtask

  initial begin
    shadow_count = 0;
    mismatches   = 0;
  end

  always @(posedge clk) begin : watch
    lookup_result_t want;
    if (rst) begin
      shadow_count = 0;
      outstanding.delete();
    end else begin
      // retire the result first so a request taken on the same edge queues behind it
      if (rsp.valid && rsp.ready) begin
        if (outstanding.size() == 0) begin
          mismatches++;
          $error("result with no request outstanding");
        end else begin
          want = outstanding.pop_front();
          check_field("ok", 32'(want.ok), 32'(rsp.ok));
          check_field("found_key", want.key, rsp.found_key);
          check_field("found_payload", want.payload, rsp.found_payload);
          check_field("entry_count", 32'(want.count), 32'(rsp.entry_count));
        end
      end
      if (req.valid && req.ready)
        outstanding.push_back(table_apply(req.func, req.req_key, req.req_payload));
    end
    fail_count    <= mismatches;
    pending_count <= outstanding.size();
  end

endmodule

`default_nettype wire

### tb/keyed_ordered_list_table_core_tb.sv
// ============================================================================
// keyed_ordered_list_table_core_tb
// drives head/tail inserts, removes, updates and searches into the table and
// lets the checker compare every result against its own shadow table
// ============================================================================
`default_nettype none

module keyed_ordered_list_table_core_tb import klot_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int PAYLOAD_BITS = PAYLOAD_BITS_DEF;

  // random part and the quiet stretch inside it
  localparam int RANDOM_ITEMS = 530;
  localparam int QUIET_FIRST  = 200;
  localparam int QUIET_LAST   = 320;
  localparam int PHASE_LEN    = 40;
  localparam int POOL_SIZE    = 8;
  localparam int IDLE_PCT     = 20;

  // the run limit leaves a wide margin over the whole directed and random run
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 8;

  // function codes the block does not define
  localparam int FN_FIRST_UNUSED = int'(FN_SEARCH) + 1;
  localparam int FN_LAST_UNUSED  = (1 << FUNC_W) - 1;

  typedef enum {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } op_mix_t;

  logic clk;
  logic rst;
  logic quiet;       // no idling on either side while set
  int   cycle_count;
  int   fail_count;
  int   pending_count;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  klot_req_if req_ch ();
  klot_rsp_if rsp_ch ();

  keyed_ordered_list_table_core #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) dut (
    .clk,
    .rst,
    .req (req_ch),
    .rsp (rsp_ch)
  );

  keyed_ordered_list_table_checker #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) table_checker (
    .clk,
    .rst,
    .req           (req_ch),
    .rsp           (rsp_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: ready drops in about one cycle of five, never while quiet
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // one request: an optional gap with valid low, then hold until taken
  task automatic send_req(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
                          input logic [PAY_IN_W-1:0] pay);
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= fn;
    req_ch.req_key     <= key;
    req_ch.req_payload <= pay;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // keys mostly come from a small pool so removes, updates and searches hit,
  // and duplicates pile up; the pool always holds the signed extremes
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  function automatic logic [PAY_IN_W-1:0] pick_payload();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return $urandom();
  endfunction

  // grow phases fill the table past full, shrink phases drain it to empty
  function automatic logic [FUNC_W-1:0] pick_func(input op_mix_t mix);
    int roll;
    int ins_pct;
    int rem_pct;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   begin ins_pct = 70; rem_pct = 10; end
      MIX_SHRINK: begin ins_pct = 20; rem_pct = 50; end
      default:    begin ins_pct = 40; rem_pct = 25; end
    endcase
    if (roll < ins_pct) return (roll % 2) ? FN_INS_TAIL : FN_INS_HEAD;
    if (roll < ins_pct + rem_pct) return FN_REMOVE;
    if (roll < 97) return (roll % 2) ? FN_UPDATE : FN_SEARCH;
    return FUNC_W'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED));
  endfunction

  initial begin
    op_mix_t mix;
    rst                = 1'b1;
    quiet              = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.func        = FN_SEARCH;
    req_ch.req_key     = '0;
    req_ch.req_payload = '0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // misses on the empty table and undefined function codes
    send_req(FN_SEARCH, 32'h0000_0000, 32'h0000_0000);
    send_req(FN_REMOVE, 32'h7fff_ffff, 32'hffff_ffff);
    send_req(FN_UPDATE, 32'h0000_0000, 32'h1234_5678);
    send_req(FUNC_W'(FN_FIRST_UNUSED), 32'hffff_ffff, 32'hffff_ffff);

    // build min_key, 0 at head, then max_key and a second min_key at tail
    send_req(FN_INS_HEAD, 32'h8000_0000, 32'hffff_ffff);
    send_req(FN_INS_TAIL, 32'h7fff_ffff, 32'h0000_0000);
    send_req(FN_INS_HEAD, 32'h0000_0000, 32'h0000_1234);
    send_req(FN_INS_TAIL, 32'h8000_0000, 32'h5555_5555);

    // duplicates: search, update and remove all take the one nearest the head
    send_req(FN_SEARCH, 32'h8000_0000, 32'h0000_0000);
    send_req(FN_UPDATE, 32'h8000_0000, 32'haaaa_aaaa);
    send_req(FN_SEARCH, 32'h8000_0000, 32'h0000_0000);
    send_req(FN_REMOVE, 32'h8000_0000, 32'h0000_0000);
    send_req(FN_SEARCH, 32'h8000_0000, 32'h0000_0000);

    // remove head, then tail, then the only entry left
    send_req(FN_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_req(FN_REMOVE, 32'h8000_0000, 32'h0000_0000);
    send_req(FN_REMOVE, 32'h7fff_ffff, 32'h0000_0000);
    send_req(FN_SEARCH, 32'h7fff_ffff, 32'h0000_0000);
    send_req(FUNC_W'(FN_LAST_UNUSED), 32'h0000_0000, 32'hffff_ffff);

    // tail insert into an empty table, then take it out again
    send_req(FN_INS_TAIL, 32'hffff_ffff, 32'h0000_0000);
    send_req(FN_REMOVE, 32'hffff_ffff, 32'h0000_0000);

    // random phases; grow phases run into the full-table case
    mix = MIX_GROW;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ((n / PHASE_LEN) % 3)
          0:       mix = MIX_GROW;
          1:       mix = MIX_SHRINK;
          default: mix = MIX_EVEN;
        endcase
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();
      end
      quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
      send_req(pick_func(mix), pick_key(), pick_payload());
    end
    quiet = 1'b0;
    req_ch.valid <= 1'b0;

    // drain: the checker's counters are registered, so they trail its own state
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/klot_pkg.sv
rtl/klot_req_if.sv
rtl/klot_rsp_if.sv
rtl/klot_cell.sv
rtl/keyed_ordered_list_table_core.sv
tb/keyed_ordered_list_table_checker.sv
tb/keyed_ordered_list_table_core_tb.sv
